### sv/sha256_byte_stream_hasher_macros.svh
// assertion macros shared by the sha256 hasher rtl
// no dependencies; included by the files that carry assertions
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SHA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SHA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sha256_pkg.sv
// shared types, codes and constant tables for the sha256 hasher
// no dependencies; imported by the controller, datapath and top level
package sha256_pkg;

  // request operation codes
  localparam logic [1:0] OP_ABSORB        = 2'd0;
  localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] OP_FINISH        = 2'd2;

  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] PAD_END    = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  typedef enum logic [1:0] {
    SEL_IN,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic       shift_byte;
    byte_sel_t  byte_sel;
    logic       add_len;
    logic       load_v;
    logic       round_en;
    logic       fold;
    logic       out_shift;
    logic [5:0] rnd;
    logic [2:0] idx;
  } dp_cmd_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

### sv/sha256_if.sv
// valid/ready channel interfaces for the sha256 hasher
// no dependencies; used by the top level ports
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

### sv/sha256_ctrl.sv
// controller fsm for the sha256 hasher: fill count, padding, rounds, digest readout
// depends on sha256_pkg and sha256_byte_stream_hasher_macros.svh
`include "sha256_byte_stream_hasher_macros.svh"

module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_index,
  output logic       out_last,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_PAD  = 2'd1;
  localparam logic [1:0] RET_OUT  = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [1:0] ret_r, ret_nxt;
  logic       pad80_r, pad80_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_index = idx_r;
  assign out_last  = (idx_r == WORD_LAST);

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    rnd_nxt      = rnd_r;
    idx_nxt      = idx_r;
    ret_nxt      = ret_r;
    pad80_nxt    = pad80_r;
    cmd          = '0;
    cmd.byte_sel = SEL_IN;
    cmd.rnd      = rnd_r;
    cmd.idx      = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          priority if (in_operation == OP_ABSORB || in_operation == OP_ABSORB_FINISH) begin
            cmd.shift_byte = 1'b1;
            cmd.add_len    = 1'b1;
            fill_nxt       = fill_r + 6'd1;
            pad80_nxt      = 1'b1;
            if (fill_r == FILL_LAST) begin
              cmd.load_v = 1'b1;
              rnd_nxt    = '0;
              state_nxt  = S_ROUND;
              ret_nxt    = (in_operation == OP_ABSORB_FINISH) ? RET_PAD : RET_IDLE;
            end else if (in_operation == OP_ABSORB_FINISH) begin
              state_nxt = S_PAD;
            end
          end else if (in_operation == OP_FINISH) begin
            pad80_nxt = 1'b1;
            state_nxt = S_PAD;
          end else begin
            // unused code, dropped
            state_nxt = S_IDLE;
          end
        end
      end
      S_PAD: begin
        if (!pad80_r && fill_r == PAD_END) begin
          state_nxt = S_LEN;
        end else begin
          cmd.shift_byte = 1'b1;
          cmd.byte_sel   = pad80_r ? SEL_PAD80 : SEL_ZERO;
          pad80_nxt      = 1'b0;
          fill_nxt       = fill_r + 6'd1;
          if (fill_r == FILL_LAST) begin
            cmd.load_v = 1'b1;
            rnd_nxt    = '0;
            state_nxt  = S_ROUND;
            ret_nxt    = RET_PAD;
          end
        end
      end
      S_LEN: begin
        cmd.shift_byte = 1'b1;
        cmd.byte_sel   = SEL_LEN;
        fill_nxt       = fill_r + 6'd1;
        if (fill_r == FILL_LAST) begin
          cmd.load_v = 1'b1;
          rnd_nxt    = '0;
          state_nxt  = S_ROUND;
          ret_nxt    = RET_OUT;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        priority if (ret_r == RET_PAD) begin
          state_nxt = S_PAD;
        end else if (ret_r == RET_OUT) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.out_shift = 1'b1;
          idx_nxt       = idx_r + 3'd1;
          if (idx_r == WORD_LAST) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      ret_r   <= RET_IDLE;
      pad80_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      ret_r   <= ret_nxt;
      pad80_r <= pad80_nxt;
    end
  end

  `SHA_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "request open during readout")
  `SHA_ASSERT_NXT(a_round_to_fold, clk, rst_n, (state_r == S_ROUND) && (rnd_r == ROUND_LAST), state_r == S_FOLD, "last round not followed by fold")
  `SHA_ASSERT_NXT(a_done_idle, clk, rst_n, out_valid && out_ready && out_last, (state_r == S_IDLE) && (fill_r == '0), "digest done but not idle and empty")
  `SHA_ASSERT_IMP(a_out_aligned, clk, rst_n, state_r == S_OUT, (fill_r == '0) && !pad80_r, "readout with bytes buffered")

endmodule

### sv/sha256_dp.sv
// datapath for the sha256 hasher: byte shift line, schedule, round unit, hash words
// depends on sha256_pkg
module sha256_dp
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  data_byte,
  output logic [31:0] digest_word
);

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [63:0] bits_r;

  logic [7:0]  byte_in;
  logic [31:0] t1, t2, w_new;

  always_comb begin
    unique case (cmd.byte_sel)
      SEL_IN:    byte_in = data_byte;
      SEL_PAD80: byte_in = PAD_BYTE;
      SEL_ZERO:  byte_in = 8'h00;
      SEL_LEN:   byte_in = bits_r[63:56];
    endcase
  end

  assign t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + ROUND_K[cmd.rnd] + w_r[0];
  assign t2 = big_sig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = small_sig1(w_r[14]) + w_r[9] + small_sig0(w_r[1]) + w_r[0];

  assign digest_word = h_r[0];

  // block words: bytes enter at w_r[15] and shift down, rounds take words from w_r[0]
  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
      end
      w_r[15] <= {w_r[15][23:0], byte_in};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.load_v) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (cmd.round_en) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
  end

  // hash words and bit length; readout rotates the initial value back in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= INIT_H[i];
      end
      bits_r <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end else if (cmd.out_shift) begin
        for (int i = 0; i < 7; i++) begin
          h_r[i] <= h_r[i+1];
        end
        h_r[7] <= INIT_H[cmd.idx];
      end
      if (cmd.add_len) begin
        bits_r <= bits_r + 64'd8;
      end else if (cmd.shift_byte && cmd.byte_sel == SEL_LEN) begin
        bits_r <= {bits_r[55:0], 8'h00};
      end
    end
  end

endmodule

### sv/sha256_byte_stream_hasher.sv
// top level of the sha256 byte stream hasher
// depends on sha256_pkg, sha256_if, sha256_ctrl and sha256_dp
//
// usage:
// - in_chan carries one request per byte: operation absorb, absorb then
//   finish, or finish alone; data_byte is ignored on finish alone, and the
//   unused operation code is taken and dropped
// - out_chan returns the digest after a finish as eight 32-bit words, most
//   significant first, with word_index 0 to 7 and last_word on the eighth
// - the 64th byte of a block starts the compression, which runs one round per
//   cycle through the 64 round constants and then folds into the hash words;
//   no further byte is taken until the block is done
// - a finish writes the pad byte, zeros and the 8 length bytes one per cycle
//   outside compression, then compresses: one block with fill at most 55, or
//   an extra block with 56 to 63, fill being the bytes buffered before the
//   pad byte; then the digest words are read out
// - in_ready is high only while the block is idle; during readout it is low
// - a stalled receiver simply holds the current digest word; nothing is lost
// - reset (rst_n low, synchronous) loads the initial hash value and clears
//   the length and fill count; the next request starts a new message
// - after the last word is taken the hash words hold the initial value again
module sha256_byte_stream_hasher
  import sha256_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  sha256_in_if.sink    in_chan,
  sha256_out_if.source out_chan
);

  dp_cmd_t     cmd;
  logic [31:0] digest;
  logic [2:0]  word_idx;
  logic        word_last;

  // sequencing: fill count, padding steps, round counter, readout index
  sha256_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_chan.ready),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_index    (word_idx),
    .out_last     (word_last),
    .cmd          (cmd)
  );

  // block words, round unit, hash words and bit length
  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_chan.data_byte),
    .digest_word (digest)
  );

  // digest word comes straight from the hash register, stable while stalled
  assign out_chan.digest_word = digest;
  assign out_chan.word_index  = word_idx;
  assign out_chan.last_word   = word_last;

endmodule
